>>> hdl/gdec_pkg.sv
// Shared types, constants and helpers of the glyph outline decoder.
`timescale 1ns / 1ps

package gdec_pkg;

  // Point storage
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int PIDX_W     = $clog2(MAX_POINTS + 1);
  localparam int FLAG_W     = 6;
  localparam int COORD_W    = 16;

  // Result kinds
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_COMP  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // Contour count of a compound glyph
  localparam logic [15:0] CONTOURS_COMPOUND = 16'hFFFF;

  // Default F2Dot14 matrix words (identity)
  localparam logic [15:0] F2DOT14_ONE = 16'h4000;
  localparam logic [63:0] MATRIX_IDENTITY = {F2DOT14_ONE, 32'h0, F2DOT14_ONE};

  // Simple glyph flag bits
  localparam int FL_ON_CURVE = 0;
  localparam int FL_X_SHORT  = 1;
  localparam int FL_Y_SHORT  = 2;
  localparam int FL_REPEAT   = 3;
  localparam int FL_X_SAME   = 4;
  localparam int FL_Y_SAME   = 5;

  // Component flag bits
  localparam int CF_WORD_ARGS = 0;
  localparam int CF_XY_VALUES = 1;
  localparam int CF_SCALE     = 3;
  localparam int CF_MORE      = 5;
  localparam int CF_XY_SCALE  = 6;
  localparam int CF_TWO_BY_TWO = 7;

  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_HEAD = 4'd1,
    PH_ENDS = 4'd2,
    PH_ILEN = 4'd3,
    PH_SKIP = 4'd4,
    PH_FLAG = 4'd5,
    PH_REP  = 4'd6,
    PH_XC   = 4'd7,
    PH_YC   = 4'd8,
    PH_COMP = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_IN   = 3'd0,
    ST_PROC = 3'd1,
    ST_REP  = 3'd2,
    ST_RD   = 3'd3,
    ST_CO   = 3'd4,
    ST_DRD  = 3'd5,
    ST_DCK  = 3'd6
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        on_curve;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] comp_flags;
    logic [15:0] comp_glyph;
    logic [15:0] scale_xx;
    logic [15:0] scale_xy;
    logic [15:0] scale_yx;
    logic [15:0] scale_yy;
    logic        last;
  } result_t;

  // Replace one 16-bit word of a 64-bit register, word 0 in the top bits
  function automatic logic [63:0] set_word(input logic [63:0] r, input logic [1:0] slot,
                                           input logic [15:0] v);
    logic [63:0] res;
    res = r;
    case (slot)
      2'd0: res[63:48] = v;
      2'd1: res[47:32] = v;
      2'd2: res[31:16] = v;
      default: res[15:0] = v;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/glyph_outline_decoder.sv
// Top level of the glyph outline decoder: stream ports, parser and output register.
// A byte is taken into a byte register and parsed from there; the parse waits while the
//   output register is full and not drained, and a finished result is registered there.
// The parser takes a new byte only after it is through with the last one; coordinate
//   bytes and points completed without a byte also pass through read and check states.
// The flag and x memories (one read port each) call for these read states.
// Reset: synchronous, active low rst_n; clears parser state, memories are not cleared.
`timescale 1ns / 1ps

module glyph_outline_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] glyph_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [0] on_curve, [16:1] coord_x, [32:17] coord_y,
                                   // [48:33] comp_flags, [64:49] comp_glyph,
                                   // [80:65] scale_xx, [96:81] scale_xy,
                                   // [112:97] scale_yx, [128:113] scale_yy, rest zero
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast
);

  logic              res_valid;
  logic              res_ready;
  gdec_pkg::result_t res;
  gdec_pkg::result_t out_r;
  logic              out_valid_r;

  gdec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {7'd0, out_r.scale_yy, out_r.scale_yx, out_r.scale_xy,
                       out_r.scale_xx, out_r.comp_glyph, out_r.comp_flags,
                       out_r.coord_y, out_r.coord_x, out_r.on_curve};

endmodule

>>> hdl/gdec_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gdec_core.sv
// Glyph record parser: byte sequencer around the flag and x coordinate memories.
`timescale 1ns / 1ps

module gdec_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  output logic              res_valid,
  input  logic              res_ready,
  output gdec_pkg::result_t res
);

  gdec_pkg::seq_state_t state_r, state_nxt;
  gdec_pkg::phase_t     phase_r, phase_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic [15:0] hep_r, hep_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  bh_r, bh_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [gdec_pkg::PIDX_W-1:0] pi_r, pi_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [gdec_pkg::FLAG_W-1:0] lastf_r, lastf_nxt;
  logic [63:0] cr0_r, cr0_nxt;
  logic [63:0] cr1_r, cr1_nxt;

  logic                         fl_we;
  logic [gdec_pkg::FLAG_W-1:0]  fl_wd;
  logic [gdec_pkg::FLAG_W-1:0]  fl_rd;
  logic                         x_we;
  logic [15:0]                  x_wd;
  logic [15:0]                  x_rd;
  logic [gdec_pkg::ADDR_W-1:0]  addr;

  logic [16:0] np17;
  logic [16:0] pi17;
  logic        pi_ge_np;

  assign addr     = pi_r[gdec_pkg::ADDR_W-1:0];
  assign np17     = {1'b0, hep_r} + 17'd1;
  assign pi17     = 17'(pi_r);
  assign pi_ge_np = (pi17 >= np17);

  // Flag and x coordinate stores
  gdec_ram #(.WIDTH(gdec_pkg::FLAG_W), .DEPTH(gdec_pkg::MAX_POINTS)) u_flag_ram (
    .clk   (clk),
    .we    (fl_we),
    .waddr (addr),
    .wdata (fl_wd),
    .raddr (addr),
    .rdata (fl_rd)
  );

  gdec_ram #(.WIDTH(gdec_pkg::COORD_W), .DEPTH(gdec_pkg::MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (addr),
    .wdata (x_wd),
    .raddr (addr),
    .rdata (x_rd)
  );

  // Hold sequencer and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdec_pkg::ST_IN;
      phase_r <= gdec_pkg::PH_WAIT;
      fc_r    <= '0;
      cc_r    <= '0;
      hep_r   <= '0;
      skip_r  <= '0;
      bh_r    <= '0;
      pi_r    <= '0;
      rep_r   <= '0;
      acc_r   <= '0;
      lastf_r <= '0;
      cr0_r   <= '0;
      cr1_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      cc_r    <= cc_nxt;
      hep_r   <= hep_nxt;
      skip_r  <= skip_nxt;
      bh_r    <= bh_nxt;
      pi_r    <= pi_nxt;
      rep_r   <= rep_nxt;
      acc_r   <= acc_nxt;
      lastf_r <= lastf_nxt;
      cr0_r   <= cr0_nxt;
      cr1_r   <= cr1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // Next state, memory writes and results
  always_comb begin
    logic [15:0] word;
    logic [15:0] vmax;
    logic [15:0] delta;
    logic [15:0] acc_new;
    logic [15:0] cf;
    logic [63:0] c0;
    logic [63:0] c1;
    logic [15:0] argb;
    logic [15:0] scb;
    logic [15:0] endp;
    logic [15:0] q;
    logic        is_x;
    logic        is_short;
    logic        is_same;
    logic [15:0] sv;

    state_nxt = state_r;
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    cc_nxt    = cc_r;
    hep_nxt   = hep_r;
    skip_nxt  = skip_r;
    bh_nxt    = bh_r;
    byte_nxt  = byte_r;
    pi_nxt    = pi_r;
    rep_nxt   = rep_r;
    acc_nxt   = acc_r;
    lastf_nxt = lastf_r;
    cr0_nxt   = cr0_r;
    cr1_nxt   = cr1_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    fl_we     = 1'b0;
    fl_wd     = byte_r[gdec_pkg::FLAG_W-1:0];
    x_we      = 1'b0;
    x_wd      = acc_r;

    word    = {bh_r, byte_r};
    vmax    = (word > hep_r) ? word : hep_r;
    is_x    = (phase_r == gdec_pkg::PH_XC);
    is_short = is_x ? fl_rd[gdec_pkg::FL_X_SHORT] : fl_rd[gdec_pkg::FL_Y_SHORT];
    is_same  = is_x ? fl_rd[gdec_pkg::FL_X_SAME] : fl_rd[gdec_pkg::FL_Y_SAME];
    if (is_short) begin
      delta = is_same ? {8'h00, byte_r} : 16'h0000 - {8'h00, byte_r};
    end else begin
      delta = word;
    end
    acc_new = acc_r + delta;
    cf   = cr0_r[63:48];
    c0   = cr0_r;
    c1   = cr1_r;
    argb = cf[gdec_pkg::CF_WORD_ARGS] ? 16'd4 : 16'd2;
    if (cf[gdec_pkg::CF_SCALE]) begin
      scb = 16'd2;
    end else if (cf[gdec_pkg::CF_XY_SCALE]) begin
      scb = 16'd4;
    end else if (cf[gdec_pkg::CF_TWO_BY_TWO]) begin
      scb = 16'd8;
    end else begin
      scb = 16'd0;
    end
    endp = 16'd4 + argb + scb;
    q    = fc_r - 16'd4 - argb;
    sv   = {((cf[gdec_pkg::CF_XY_VALUES] && byte_r[7]) ? 8'hFF : 8'h00), byte_r};

    unique case (state_r)
      // Take the next byte; a record start clears the parse state
      gdec_pkg::ST_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          byte_nxt  = in_byte;
          state_nxt = gdec_pkg::ST_PROC;
          if (in_start) begin
            phase_nxt = gdec_pkg::PH_HEAD;
            fc_nxt    = '0;
            cc_nxt    = '0;
            hep_nxt   = '0;
            skip_nxt  = '0;
            pi_nxt    = '0;
            rep_nxt   = '0;
            acc_nxt   = '0;
          end
        end
      end

      // Parse a header, end point, instruction, flag, repeat or component byte
      gdec_pkg::ST_PROC: begin
        if (res_ready) begin
          state_nxt = gdec_pkg::ST_IN;
          unique case (phase_r)
            gdec_pkg::PH_HEAD: begin
              if (fc_r == 16'd0) begin
                bh_nxt = byte_r;
              end else if (fc_r == 16'd1) begin
                cc_nxt = word;
              end
              if (fc_r < 16'd9) begin
                fc_nxt = fc_r + 16'd1;
              end else begin
                fc_nxt = '0;
                if (cc_r == gdec_pkg::CONTOURS_COMPOUND) begin
                  phase_nxt = gdec_pkg::PH_COMP;
                end else if (cc_r[15]) begin
                  res_valid = 1'b1;
                  res.kind  = gdec_pkg::KIND_BAD;
                  res.last  = 1'b1;
                  phase_nxt = gdec_pkg::PH_WAIT;
                end else if (cc_r == 16'd0) begin
                  phase_nxt = gdec_pkg::PH_ILEN;
                end else begin
                  phase_nxt = gdec_pkg::PH_ENDS;
                end
              end
            end
            gdec_pkg::PH_ENDS: begin
              if (fc_r[0]) begin
                hep_nxt = vmax;
                if (vmax >= 16'(gdec_pkg::MAX_POINTS)) begin
                  res_valid = 1'b1;
                  res.kind  = gdec_pkg::KIND_BAD;
                  res.last  = 1'b1;
                  phase_nxt = gdec_pkg::PH_WAIT;
                end else if (({1'b0, fc_r} + 17'd1) == {cc_r, 1'b0}) begin
                  phase_nxt = gdec_pkg::PH_ILEN;
                  fc_nxt    = '0;
                end else begin
                  fc_nxt = fc_r + 16'd1;
                end
              end else begin
                bh_nxt = byte_r;
                fc_nxt = fc_r + 16'd1;
              end
            end
            gdec_pkg::PH_ILEN: begin
              if (fc_r == 16'd0) begin
                bh_nxt = byte_r;
                fc_nxt = 16'd1;
              end else begin
                fc_nxt   = '0;
                skip_nxt = word;
                if (word != 16'd0) begin
                  phase_nxt = gdec_pkg::PH_SKIP;
                end else if (cc_r == 16'd0) begin
                  phase_nxt = gdec_pkg::PH_WAIT;
                end else begin
                  phase_nxt = gdec_pkg::PH_FLAG;
                  pi_nxt    = '0;
                end
              end
            end
            gdec_pkg::PH_SKIP: begin
              skip_nxt = skip_r - 16'd1;
              if (skip_r == 16'd1) begin
                if (cc_r == 16'd0) begin
                  phase_nxt = gdec_pkg::PH_WAIT;
                end else begin
                  phase_nxt = gdec_pkg::PH_FLAG;
                  pi_nxt    = '0;
                end
              end
            end
            gdec_pkg::PH_FLAG: begin
              if (pi_ge_np) begin
                res_valid = 1'b1;
                res.kind  = gdec_pkg::KIND_BAD;
                res.last  = 1'b1;
                phase_nxt = gdec_pkg::PH_WAIT;
              end else begin
                fl_we     = 1'b1;
                lastf_nxt = byte_r[gdec_pkg::FLAG_W-1:0];
                pi_nxt    = pi_r + 1'b1;
                if (byte_r[gdec_pkg::FL_REPEAT]) begin
                  phase_nxt = gdec_pkg::PH_REP;
                end else if ((pi17 + 17'd1) >= np17) begin
                  phase_nxt = gdec_pkg::PH_XC;
                  pi_nxt    = '0;
                  acc_nxt   = '0;
                  fc_nxt    = '0;
                  state_nxt = gdec_pkg::ST_DRD;
                end
              end
            end
            gdec_pkg::PH_REP: begin
              if ((pi17 + 17'(byte_r)) > np17 || pi_r == '0) begin
                res_valid = 1'b1;
                res.kind  = gdec_pkg::KIND_BAD;
                res.last  = 1'b1;
                phase_nxt = gdec_pkg::PH_WAIT;
              end else begin
                rep_nxt   = byte_r;
                state_nxt = gdec_pkg::ST_REP;
              end
            end
            gdec_pkg::PH_XC, gdec_pkg::PH_YC: begin
              state_nxt = gdec_pkg::ST_RD;
            end
            gdec_pkg::PH_COMP: begin
              if (fc_r == 16'd0) begin
                c0 = '0;
                c1 = gdec_pkg::MATRIX_IDENTITY;
              end
              if (fc_r < 16'd4) begin
                if (fc_r[0]) begin
                  c0 = gdec_pkg::set_word(c0, fc_r[2:1], word);
                end else begin
                  bh_nxt = byte_r;
                end
                fc_nxt = fc_r + 16'd1;
              end else begin
                if (fc_r < 16'd4 + argb) begin
                  if (argb == 16'd4) begin
                    if (fc_r[0]) begin
                      c0 = gdec_pkg::set_word(c0, {1'b1, fc_r[1]}, word);
                    end else begin
                      bh_nxt = byte_r;
                    end
                  end else begin
                    c0 = gdec_pkg::set_word(c0, {1'b1, fc_r[0]}, sv);
                  end
                end else begin
                  if (q[0]) begin
                    if (scb == 16'd2) begin
                      c1 = gdec_pkg::set_word(c1, 2'd0, word);
                      c1 = gdec_pkg::set_word(c1, 2'd3, word);
                    end else if (scb == 16'd4) begin
                      c1 = gdec_pkg::set_word(c1, q[1] ? 2'd3 : 2'd0, word);
                    end else begin
                      c1 = gdec_pkg::set_word(c1, q[2:1], word);
                    end
                  end else begin
                    bh_nxt = byte_r;
                  end
                end
                if (fc_r + 16'd1 == endp) begin
                  res_valid      = 1'b1;
                  res.kind       = gdec_pkg::KIND_COMP;
                  res.coord_x    = c0[31:16];
                  res.coord_y    = c0[15:0];
                  res.comp_flags = cf;
                  res.comp_glyph = c0[47:32];
                  res.scale_xx   = c1[63:48];
                  res.scale_xy   = c1[47:32];
                  res.scale_yx   = c1[31:16];
                  res.scale_yy   = c1[15:0];
                  res.last       = !cf[gdec_pkg::CF_MORE];
                  if (cf[gdec_pkg::CF_MORE]) begin
                    fc_nxt = '0;
                  end else begin
                    phase_nxt = gdec_pkg::PH_WAIT;
                  end
                end else begin
                  fc_nxt = fc_r + 16'd1;
                end
              end
              cr0_nxt = c0;
              cr1_nxt = c1;
            end
            default: begin
              phase_nxt = gdec_pkg::PH_WAIT;
            end
          endcase
        end
      end

      // Copy the previous flag once per cycle for a repeat run
      gdec_pkg::ST_REP: begin
        if (rep_r == 8'd0) begin
          if (pi_ge_np) begin
            phase_nxt = gdec_pkg::PH_XC;
            pi_nxt    = '0;
            acc_nxt   = '0;
            fc_nxt    = '0;
            state_nxt = gdec_pkg::ST_DRD;
          end else begin
            phase_nxt = gdec_pkg::PH_FLAG;
            state_nxt = gdec_pkg::ST_IN;
          end
        end else begin
          fl_we   = 1'b1;
          fl_wd   = lastf_r;
          pi_nxt  = pi_r + 1'b1;
          rep_nxt = rep_r - 8'd1;
        end
      end

      // Wait for the flag and x of the current point
      gdec_pkg::ST_RD: begin
        state_nxt = gdec_pkg::ST_CO;
      end

      // Apply one coordinate byte
      gdec_pkg::ST_CO: begin
        if (pi_ge_np) begin
          phase_nxt = gdec_pkg::PH_WAIT;
          state_nxt = gdec_pkg::ST_IN;
        end else if (is_short || fc_r != 16'd0) begin
          if (is_x) begin
            x_we      = 1'b1;
            x_wd      = acc_new;
            acc_nxt   = acc_new;
            pi_nxt    = pi_r + 1'b1;
            fc_nxt    = '0;
            state_nxt = gdec_pkg::ST_DRD;
          end else begin
            res_valid    = 1'b1;
            res.kind     = gdec_pkg::KIND_POINT;
            res.on_curve = fl_rd[gdec_pkg::FL_ON_CURVE];
            res.coord_x  = x_rd;
            res.coord_y  = acc_new;
            res.last     = (pi17 + 17'd1) == np17;
            if (res_ready) begin
              acc_nxt   = acc_new;
              pi_nxt    = pi_r + 1'b1;
              fc_nxt    = '0;
              state_nxt = gdec_pkg::ST_DRD;
            end
          end
        end else begin
          bh_nxt    = byte_r;
          fc_nxt    = 16'd1;
          state_nxt = gdec_pkg::ST_IN;
        end
      end

      // Advance the coordinate pass, issue the read of the next point
      gdec_pkg::ST_DRD: begin
        if (phase_r == gdec_pkg::PH_XC && pi_ge_np) begin
          phase_nxt = gdec_pkg::PH_YC;
          pi_nxt    = '0;
          acc_nxt   = '0;
          fc_nxt    = '0;
        end else if (phase_r == gdec_pkg::PH_YC && pi_ge_np) begin
          phase_nxt = gdec_pkg::PH_WAIT;
          state_nxt = gdec_pkg::ST_IN;
        end else if (phase_r == gdec_pkg::PH_XC || phase_r == gdec_pkg::PH_YC) begin
          state_nxt = gdec_pkg::ST_DCK;
        end else begin
          state_nxt = gdec_pkg::ST_IN;
        end
      end

      // Complete points that need no coordinate byte
      gdec_pkg::ST_DCK: begin
        if (is_short || !is_same) begin
          state_nxt = gdec_pkg::ST_IN;
        end else if (is_x) begin
          x_we      = 1'b1;
          pi_nxt    = pi_r + 1'b1;
          state_nxt = gdec_pkg::ST_DRD;
        end else begin
          res_valid    = 1'b1;
          res.kind     = gdec_pkg::KIND_POINT;
          res.on_curve = fl_rd[gdec_pkg::FL_ON_CURVE];
          res.coord_x  = x_rd;
          res.coord_y  = acc_r;
          res.last     = (pi17 + 17'd1) == np17;
          if (res_ready) begin
            pi_nxt    = pi_r + 1'b1;
            state_nxt = gdec_pkg::ST_DRD;
          end
        end
      end

      default: begin
        state_nxt = gdec_pkg::ST_IN;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Memory writes stay inside the stores
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fl_we || x_we) |-> (pi17 < 17'(gdec_pkg::MAX_POINTS)))
    else $error("store write past the last point");

  // Coordinate states only run in a coordinate pass
  a_coord_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdec_pkg::ST_CO || state_r == gdec_pkg::ST_DCK) |->
    (phase_r == gdec_pkg::PH_XC || phase_r == gdec_pkg::PH_YC))
    else $error("coordinate state outside a coordinate pass");

  // A read wait is always followed by the coordinate state
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gdec_pkg::ST_RD) |=> (state_r == gdec_pkg::ST_CO))
    else $error("read wait did not advance");

  // A malformed result always ends the glyph
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == gdec_pkg::KIND_BAD) |-> res.last)
    else $error("malformed result without last");
`endif

endmodule

>>> verif/glyph_outline_decoder_checker.sv
// Stream monitor, outline predictor and result scoreboard for the glyph outline decoder.
`timescale 1ns / 1ps

module glyph_outline_decoder_checker
  import gdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  // Predictor state
  phase_t      ph;
  logic [15:0] fld;
  logic [15:0] ncont;
  logic [15:0] hi_end;
  logic [15:0] skip_left;
  logic [15:0] acc;
  logic [7:0]  hold_b;
  int          pidx;
  logic [5:0]  flag_mem [MAX_POINTS];
  logic [15:0] x_mem [MAX_POINTS];
  logic [63:0] comp_args;
  logic [63:0] comp_mat;
  result_t     outline_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [63:0] with_word(input logic [63:0] r, input int slot,
                                            input logic [15:0] v);
    logic [63:0] res;
    res = r;
    res[(3 - slot) * 16 +: 16] = v;
    return res;
  endfunction

  function automatic int point_total();
    return int'(hi_end) + 1;
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic on, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] cf,
                             input logic [15:0] cg, input logic [63:0] mat, input logic last);
    result_t r;
    r.kind = kind;
    r.on_curve = on;
    r.coord_x = x;
    r.coord_y = y;
    r.comp_flags = cf;
    r.comp_glyph = cg;
    r.scale_xx = mat[63:48];
    r.scale_xy = mat[47:32];
    r.scale_yx = mat[31:16];
    r.scale_yy = mat[15:0];
    r.last = last;
    outline_q.push_back(r);
  endtask

  task automatic flag_bad();
    push_result(KIND_BAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 64'h0, 1'b1);
    ph = PH_WAIT;
  endtask

  // Emit points whose y needs no byte
  task automatic drain_y();
    logic [5:0] f;
    while (ph == PH_YC && pidx < point_total() && pidx < MAX_POINTS) begin
      f = flag_mem[pidx];
      if (f[FL_Y_SHORT] || !f[FL_Y_SAME]) break;
      push_result(KIND_POINT, f[FL_ON_CURVE], x_mem[pidx], acc, 16'h0, 16'h0, 64'h0,
                  pidx + 1 == point_total());
      pidx++;
    end
    if (ph == PH_YC && pidx >= point_total()) ph = PH_WAIT;
  endtask

  // Fill x of points whose x needs no byte
  task automatic drain_x();
    logic [5:0] f;
    while (ph == PH_XC && pidx < point_total() && pidx < MAX_POINTS) begin
      f = flag_mem[pidx];
      if (f[FL_X_SHORT] || !f[FL_X_SAME]) break;
      x_mem[pidx] = acc;
      pidx++;
    end
    if (ph == PH_XC && pidx >= point_total()) begin
      ph = PH_YC;
      pidx = 0;
      acc = 16'h0;
      fld = 16'h0;
    end
    drain_y();
  endtask

  task automatic start_coords();
    ph = PH_XC;
    pidx = 0;
    acc = 16'h0;
    fld = 16'h0;
    drain_x();
  endtask

  task automatic instructions_done();
    if (ncont == 16'h0) begin
      ph = PH_WAIT;
    end else begin
      ph = PH_FLAG;
      pidx = 0;
    end
  endtask

  task automatic coord_step(input logic [7:0] b);
    logic       is_x;
    logic [5:0] f;
    logic       short_b;
    logic       same_b;
    logic [15:0] delta;
    if (pidx >= MAX_POINTS || pidx >= point_total()) begin
      ph = PH_WAIT;
      return;
    end
    is_x = (ph == PH_XC);
    f = flag_mem[pidx];
    short_b = is_x ? f[FL_X_SHORT] : f[FL_Y_SHORT];
    same_b = is_x ? f[FL_X_SAME] : f[FL_Y_SAME];
    if (short_b) begin
      delta = same_b ? {8'h0, b} : (16'h0 - {8'h0, b});
    end else if (fld == 16'h0) begin
      hold_b = b;
      fld = 16'h1;
      return;
    end else begin
      delta = {hold_b, b};
    end
    fld = 16'h0;
    acc = acc + delta;
    if (is_x) begin
      x_mem[pidx] = acc;
      pidx++;
      drain_x();
    end else begin
      push_result(KIND_POINT, f[FL_ON_CURVE], x_mem[pidx], acc, 16'h0, 16'h0, 64'h0,
                  pidx + 1 == point_total());
      pidx++;
      drain_y();
    end
  endtask

  task automatic comp_step(input logic [7:0] b);
    int          p;
    int          arg_n;
    int          scale_n;
    int          q;
    logic [15:0] f;
    logic [15:0] v;
    p = int'(fld);
    f = comp_args[63:48];
    if (p == 0) begin
      comp_args = 64'h0;
      comp_mat = MATRIX_IDENTITY;
    end
    // flag word and glyph index
    if (p < 4) begin
      if (p % 2 == 1) comp_args = with_word(comp_args, p / 2, {hold_b, b});
      else hold_b = b;
      fld++;
      return;
    end
    arg_n = f[CF_WORD_ARGS] ? 4 : 2;
    scale_n = f[CF_SCALE] ? 2 : f[CF_XY_SCALE] ? 4 : f[CF_TWO_BY_TWO] ? 8 : 0;
    if (p < 4 + arg_n) begin
      if (arg_n == 4) begin
        if (p % 2 == 1) comp_args = with_word(comp_args, 2 + (p - 4) / 2, {hold_b, b});
        else hold_b = b;
      end else begin
        v = {8'h0, b};
        if (f[CF_XY_VALUES] && b[7]) v[15:8] = 8'hFF;
        comp_args = with_word(comp_args, 2 + (p - 4), v);
      end
    end else begin
      q = p - 4 - arg_n;
      if (q % 2 == 1) begin
        v = {hold_b, b};
        if (scale_n == 2) begin
          comp_mat = with_word(comp_mat, 0, v);
          comp_mat = with_word(comp_mat, 3, v);
        end else if (scale_n == 4) begin
          comp_mat = with_word(comp_mat, (q / 2 != 0) ? 3 : 0, v);
        end else begin
          comp_mat = with_word(comp_mat, q / 2, v);
        end
      end else begin
        hold_b = b;
      end
    end
    if (p + 1 == 4 + arg_n + scale_n) begin
      push_result(KIND_COMP, 1'b0, comp_args[31:16], comp_args[15:0], f, comp_args[47:32],
                  comp_mat, !f[CF_MORE]);
      if (f[CF_MORE]) fld = 16'h0;
      else ph = PH_WAIT;
    end else begin
      fld++;
    end
  endtask

  // Advance the predictor by one record byte
  task automatic parse_byte(input logic [7:0] b, input logic first);
    logic [15:0] v;
    int          r;
    if (first) begin
      ph = PH_HEAD;
      fld = 16'h0;
      ncont = 16'h0;
      hi_end = 16'h0;
      skip_left = 16'h0;
      pidx = 0;
      acc = 16'h0;
    end
    case (ph)
      PH_HEAD: begin
        if (fld == 16'h0) hold_b = b;
        else if (fld == 16'h1) ncont = {hold_b, b};
        if (fld < 16'd9) begin
          fld++;
        end else begin
          fld = 16'h0;
          if (ncont == CONTOURS_COMPOUND) ph = PH_COMP;
          else if (ncont[15]) flag_bad();
          else if (ncont == 16'h0) ph = PH_ILEN;
          else ph = PH_ENDS;
        end
      end
      PH_ENDS: begin
        if (fld[0]) begin
          v = {hold_b, b};
          if (v > hi_end) hi_end = v;
          if (hi_end >= MAX_POINTS) begin
            flag_bad();
          end else if (int'(fld) + 1 == 2 * int'(ncont)) begin
            ph = PH_ILEN;
            fld = 16'h0;
          end else begin
            fld++;
          end
        end else begin
          hold_b = b;
          fld++;
        end
      end
      PH_ILEN: begin
        if (fld == 16'h0) begin
          hold_b = b;
          fld = 16'h1;
        end else begin
          fld = 16'h0;
          skip_left = {hold_b, b};
          if (skip_left == 16'h0) instructions_done();
          else ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 16'h0) instructions_done();
      end
      PH_FLAG: begin
        if (pidx >= MAX_POINTS || pidx >= point_total()) begin
          flag_bad();
        end else begin
          flag_mem[pidx] = b[5:0];
          pidx++;
          if (b[FL_REPEAT]) ph = PH_REP;
          else if (pidx >= point_total()) start_coords();
        end
      end
      PH_REP: begin
        if (pidx + int'(b) > point_total() || pidx == 0) begin
          flag_bad();
        end else begin
          r = int'(b);
          while (r > 0 && pidx < MAX_POINTS) begin
            flag_mem[pidx] = flag_mem[pidx - 1];
            pidx++;
            r--;
          end
          if (pidx >= point_total()) start_coords();
          else ph = PH_FLAG;
        end
      end
      PH_XC, PH_YC: coord_step(b);
      PH_COMP: comp_step(b);
      default: ph = PH_WAIT;
    endcase
  endtask

  // Watch both channels, predict and compare
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      ph = PH_WAIT;
      fld = 16'h0;
      ncont = 16'h0;
      hi_end = 16'h0;
      skip_left = 16'h0;
      acc = 16'h0;
      hold_b = 8'h0;
      pidx = 0;
      comp_args = 64'h0;
      comp_mat = 64'h0;
      outline_q.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.on_curve = out_tdata[0];
        got.coord_x = out_tdata[16:1];
        got.coord_y = out_tdata[32:17];
        got.comp_flags = out_tdata[48:33];
        got.comp_glyph = out_tdata[64:49];
        got.scale_xx = out_tdata[80:65];
        got.scale_xy = out_tdata[96:81];
        got.scale_yx = out_tdata[112:97];
        got.scale_yy = out_tdata[128:113];
        got.last = out_tlast;
        if (outline_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %p", $realtime, got);
        end else begin
          want = outline_q.pop_front();
          if (got.kind !== want.kind || got.on_curve !== want.on_curve ||
              got.coord_x !== want.coord_x || got.coord_y !== want.coord_y ||
              got.comp_flags !== want.comp_flags || got.comp_glyph !== want.comp_glyph ||
              got.scale_xx !== want.scale_xx || got.scale_xy !== want.scale_xy ||
              got.scale_yx !== want.scale_yx || got.scale_yy !== want.scale_yy ||
              got.last !== want.last || out_tdata[135:129] !== 7'h0) begin
            fail_count++;
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
    end
    pending = outline_q.size();
  end

  final_check_unused: assert property (@(posedge clk) 1'b1);

endmodule

>>> verif/glyph_outline_decoder_tb.sv
// Top of the glyph outline decoder testbench: clock, reset, record stimulus and verdict.
`timescale 1ns / 1ps

module glyph_outline_decoder_tb;
  import gdec_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  int           fail_count;
  int           pending;

  int           tx_idle_pct;
  int           rx_idle_pct;
  logic         rx_hold = 1'b0;
  int           quiet_cycles = 0;
  logic [8:0]   record_q [$];   // {glyph_start, data_byte}

  glyph_outline_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  glyph_outline_decoder_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive result backpressure
  always @(negedge clk) begin
    out_tready = rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("glyph_outline_decoder verification failed");
        $finish;
      end
    end
  end

  task automatic add_byte(input int b, input logic first = 1'b0);
    record_q.push_back({first, 8'(b)});
  endtask

  task automatic add_word(input int w, input logic first = 1'b0);
    add_byte((w >> 8) & 8'hFF, first);
    add_byte(w & 8'hFF);
  endtask

  task automatic add_header(input int contours);
    add_word(contours, 1'b1);
    repeat (8) add_byte($urandom_range(255));
  endtask

  // Simple glyph with random flags and coordinates; well-formed while npts >= ncont
  task automatic make_simple(input int npts, input int ncont, input int reps_pct);
    logic [7:0] fl [MAX_POINTS];
    logic [7:0] f;
    int         i;
    int         r;
    int         ilen;
    add_header(ncont);
    for (int k = 0; k < ncont; k++)
      add_word((k == ncont - 1) ? npts - 1 : (k + 1) * npts / ncont - 1);
    ilen = $urandom_range(3);
    add_word(ilen);
    repeat (ilen) add_byte($urandom_range(255));
    i = 0;
    while (i < npts) begin
      f = 8'($urandom);
      f[FL_REPEAT] = 1'b0;
      if (i < npts - 1 && $urandom_range(99) < reps_pct) begin
        f[FL_REPEAT] = 1'b1;
        r = $urandom_range(npts - 1 - i);
        add_byte(f);
        add_byte(r);
      end else begin
        r = 0;
        add_byte(f);
      end
      for (int j = 0; j <= r; j++) fl[i + j] = f;
      i += r + 1;
    end
    for (int j = 0; j < npts; j++) begin
      if (fl[j][FL_X_SHORT]) add_byte($urandom_range(255));
      else if (!fl[j][FL_X_SAME]) add_word($urandom_range(16'hFFFF));
    end
    for (int j = 0; j < npts; j++) begin
      if (fl[j][FL_Y_SHORT]) add_byte($urandom_range(255));
      else if (!fl[j][FL_Y_SAME]) add_word($urandom_range(16'hFFFF));
    end
  endtask

  // Compound glyph; scale_sel 0 none, 1 one scale, 2 x and y, 3 two by two, 4 any bits
  task automatic make_compound(input int ncomp, input int scale_sel);
    logic [15:0] cf;
    int          sel;
    int          nscale;
    add_header(CONTOURS_COMPOUND);
    for (int c = 0; c < ncomp; c++) begin
      cf = 16'($urandom);
      cf[CF_MORE] = (c < ncomp - 1);
      sel = (scale_sel < 0) ? $urandom_range(4) : scale_sel;
      if (sel != 4) begin
        cf[CF_SCALE] = (sel == 1);
        cf[CF_XY_SCALE] = (sel == 2);
        cf[CF_TWO_BY_TWO] = (sel == 3);
      end
      nscale = cf[CF_SCALE] ? 2 : cf[CF_XY_SCALE] ? 4 : cf[CF_TWO_BY_TWO] ? 8 : 0;
      add_word(cf);
      add_word($urandom_range(16'hFFFF));
      repeat (cf[CF_WORD_ARGS] ? 4 : 2) add_byte($urandom_range(255));
      repeat (nscale) add_byte($urandom_range(255));
    end
  endtask

  task automatic make_bad_count();
    if ($urandom_range(1)) add_word(16'h8000 + $urandom_range(16'h7EFF), 1'b1);
    else add_word(16'hFF00 + $urandom_range(16'hFE), 1'b1);
    repeat (8) add_byte($urandom_range(255));
  endtask

  task automatic make_bad_points();
    add_header($urandom_range(1, 2));
    add_word($urandom_range(MAX_POINTS, 16'hFFFF));
  endtask

  task automatic make_bad_repeat();
    int npts;
    npts = $urandom_range(1, 8);
    add_header(1);
    add_word(npts - 1);
    add_word(0);
    add_byte(8'h08 | 8'($urandom_range(255)));
    add_byte($urandom_range(npts, 255));
  endtask

  task automatic make_empty();
    int ilen;
    ilen = $urandom_range(4);
    add_header(0);
    add_word(ilen);
    repeat (ilen) add_byte($urandom_range(255));
  endtask

  task automatic make_noise();
    repeat ($urandom_range(1, 4)) add_byte($urandom_range(255));
  endtask

  // Mostly well-formed records; the rest broken, cut short or noise
  task automatic make_random_record();
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 55) make_simple($urandom_range(1, 10), $urandom_range(1, 3), 30);
    else if (pick < 75) make_compound($urandom_range(1, 3), -1);
    else if (pick < 79) make_bad_count();
    else if (pick < 83) make_bad_points();
    else if (pick < 87) make_bad_repeat();
    else if (pick < 90) make_empty();
    else if (pick < 95) make_noise();
    else begin
      cut = record_q.size();
      make_simple($urandom_range(2, 10), 1, 30);
      cut += $urandom_range(1, record_q.size() - cut - 1);
      while (record_q.size() > cut) void'(record_q.pop_back());
    end
  endtask

  // Send every queued byte, idling between transactions at random
  task automatic send_records();
    logic [8:0] item;
    while (record_q.size() > 0) begin
      item = record_q.pop_front();
      @(negedge clk);
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata = item[7:0];
      in_tuser = item[8];
      do @(posedge clk); while (!in_tready);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    tx_idle_pct = 8;
    rx_idle_pct = 51;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed records
    make_noise();
    make_simple(1, 1, 0);
    make_simple(5, 5, 50);
    make_simple(MAX_POINTS, 3, 40);
    for (int s = 0; s < 5; s++) make_compound(2, s);
    make_bad_count();
    make_bad_points();
    make_bad_repeat();
    make_empty();
    add_header(1);
    add_word(3);
    add_word(0);
    add_byte(8'h39);  // all points zero-length, one repeat byte completes them
    add_byte(3);
    add_header(2);
    add_word(0);     // record dropped by the next glyph start
    make_simple(4, 2, 0);
    send_records();
    wait_drained();

    for (int ph_i = 0; ph_i < 3; ph_i++) begin
      if (ph_i == 1) begin
        tx_idle_pct = 51;
        rx_idle_pct = 8;
      end else if (ph_i == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      while (record_q.size() < 100) make_random_record();
      send_records();
      // in the first round, pause until every pending result has come out
      if (ph_i == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("glyph_outline_decoder verification clean");
    end else begin
      $display("glyph_outline_decoder verification failed");
    end
    $finish;
  end

endmodule
